>>> hw/rtl/ssym_pkg.sv
// ----------------------------------------------------------------------------
// ssym_pkg
// Shared codes for the scoped symbol table: operation, status and control
// state encodings.
// ----------------------------------------------------------------------------
package ssym_pkg;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_POP    = 2'd2,
    MODE_FIND   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_NO_LEVEL    = 3'd1,
    ST_LEVEL_FULL  = 3'd2,
    ST_TABLE_FULL  = 3'd3,
    ST_POP_EMPTY   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CTRL_IDLE = 2'd0,
    CTRL_SCAN = 2'd1,
    CTRL_DONE = 2'd2
  } ctrl_state_e;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned IdW     = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OutLvlW = 4;
  localparam int unsigned DepthW  = 5;

endpackage

>>> hw/rtl/ssym_cell.sv
// ----------------------------------------------------------------------------
// ssym_cell
// One entry of the symbol table. Holds key, owning level and valid bit, and
// updates the search token as it passes through on its way down the chain.
// ----------------------------------------------------------------------------
module ssym_cell #(
  parameter int unsigned KeyW    = 32,
  parameter int unsigned LevelW  = 4,
  parameter int unsigned IdxW    = 6,
  parameter int unsigned CellIdx = 0
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic [KeyW+LevelW+IdxW+LevelW+ssym_pkg::ModeW+5-1:0] tok_i,
  output logic [KeyW+LevelW+IdxW+LevelW+ssym_pkg::ModeW+5-1:0] tok_o,
  input  logic [IdxW+KeyW+LevelW:0] wr_i
);

  typedef struct packed {
    logic                  active;
    ssym_pkg::mode_e       mode;
    logic                  scope_ok;
    logic [KeyW-1:0]       key;
    logic [LevelW-1:0]     top;
    logic                  hit_top;
    logic                  outer_hit;
    logic [LevelW-1:0]     outer_level;
    logic                  free_found;
    logic [IdxW-1:0]       free_idx;
  } tok_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [KeyW-1:0]   key;
    logic [LevelW-1:0] level;
  } wr_t;

  tok_t              tok_in, tok_d, tok_q;
  wr_t               wr;
  logic              valid_d, valid_q;
  logic [KeyW-1:0]   key_q;
  logic [LevelW-1:0] level_q;
  logic              key_match, searching, wr_sel;

  assign tok_in = tok_i;
  assign wr     = wr_i;
  assign tok_o  = tok_q;
  assign wr_sel = wr.en && (wr.idx == IdxW'(CellIdx));

  always_comb begin
    tok_d     = tok_in;
    valid_d   = valid_q;
    key_match = valid_q && (key_q == tok_in.key);
    searching = tok_in.active && tok_in.scope_ok &&
                ((tok_in.mode == ssym_pkg::MODE_INSERT) ||
                 (tok_in.mode == ssym_pkg::MODE_FIND));
    if (searching) begin
      if (key_match && (level_q == tok_in.top)) begin
        tok_d.hit_top = 1'b1;
      end
      // nearest outer level wins: keep the highest level below the top
      if (key_match && (level_q < tok_in.top) &&
          (!tok_in.outer_hit || (level_q > tok_in.outer_level))) begin
        tok_d.outer_hit   = 1'b1;
        tok_d.outer_level = level_q;
      end
      if (!valid_q && !tok_in.free_found) begin
        tok_d.free_found = 1'b1;
        tok_d.free_idx   = IdxW'(CellIdx);
      end
    end
    if (tok_in.active && tok_in.scope_ok && (tok_in.mode == ssym_pkg::MODE_POP) &&
        valid_q && (level_q == tok_in.top)) begin
      valid_d = 1'b0;
    end
    if (wr_sel) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel) begin
      key_q   <= wr.key;
      level_q <= wr.level;
    end
  end

endmodule

>>> hw/rtl/scoped_symbol_table.sv
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Stack of scope levels over a chain of tagged entry cells. A search token
// walks the chain once per item, collecting top hit, nearest shadow level and
// the first free slot; inserts are written back once the token leaves.
// ----------------------------------------------------------------------------
//  channel | direction | signals
//  --------+-----------+-----------------------------------------------------
//  in      | sink      | in_valid_i, in_ready_o, mode_i, id_value_i
//  out     | source    | out_valid_o, out_ready_i, status_o, hit_top_o,
//          |           | outer_hit_o, outer_level_o, depth_o
//
//  On acceptance the token enters the first cell at the accepting edge and is
//  registered in each further cell in turn; the result register then collects
//  it, and the controller updates state and loads the output register. One
//  item is in work at a time; the next is taken once the result is loaded,
//  even while that result still waits on out_ready_i.
//  A stalled output holds the block in its final step until taken.
//  Reset clears the level count and all entry valid bits at once.
// ----------------------------------------------------------------------------
module scoped_symbol_table #(
  parameter int unsigned MAX_LEVELS  = 16,
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned ID_WIDTH    = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [ssym_pkg::ModeW-1:0]          mode_i,
  input  logic signed [ssym_pkg::IdW-1:0]     id_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [ssym_pkg::StatusW-1:0]        status_o,
  output logic                                hit_top_o,
  output logic                                outer_hit_o,
  output logic [ssym_pkg::OutLvlW-1:0]        outer_level_o,
  output logic [ssym_pkg::DepthW-1:0]         depth_o
);

  localparam int unsigned LevelW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned DepthW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned IdxW   = $clog2(MAX_ENTRIES);
  localparam int unsigned TokW   = ID_WIDTH + LevelW + IdxW + LevelW + ssym_pkg::ModeW + 5;
  localparam int unsigned WrW    = IdxW + ID_WIDTH + LevelW + 1;

  typedef struct packed {
    logic                  active;
    ssym_pkg::mode_e       mode;
    logic                  scope_ok;
    logic [ID_WIDTH-1:0]   key;
    logic [LevelW-1:0]     top;
    logic                  hit_top;
    logic                  outer_hit;
    logic [LevelW-1:0]     outer_level;
    logic                  free_found;
    logic [IdxW-1:0]       free_idx;
  } tok_t;

  typedef struct packed {
    logic                  en;
    logic [IdxW-1:0]       idx;
    logic [ID_WIDTH-1:0]   key;
    logic [LevelW-1:0]     level;
  } wr_t;

  ssym_pkg::ctrl_state_e state_d, state_q;
  logic [TokW-1:0]       chain [MAX_ENTRIES+1];
  tok_t                  head_tok, tail_tok, res_q;
  wr_t                   wr;
  logic [DepthW-1:0]     depth_d, depth_q;
  logic [ssym_pkg::IdW-1:0] id_bits;
  logic                  in_fire, out_load;

  ssym_pkg::status_e     status_d, status_q;
  logic                  hit_top_d, hit_top_q;
  logic                  outer_hit_d, outer_hit_q;
  logic [LevelW-1:0]     outer_level_d, outer_level_q;
  logic                  out_valid_q;

  assign id_bits  = id_value_i;
  assign in_fire  = in_valid_i && in_ready_o;
  assign chain[0] = head_tok;
  assign tail_tok = chain[MAX_ENTRIES];

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    ssym_cell #(
      .KeyW    (ID_WIDTH),
      .LevelW  (LevelW),
      .IdxW    (IdxW),
      .CellIdx (g)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .tok_i  (chain[g]),
      .tok_o  (chain[g+1]),
      .wr_i   (WrW'(wr))
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssym_pkg::CTRL_IDLE: if (in_fire) state_d = ssym_pkg::CTRL_SCAN;
      ssym_pkg::CTRL_SCAN: if (tail_tok.active) state_d = ssym_pkg::CTRL_DONE;
      ssym_pkg::CTRL_DONE: if (!out_valid_q || out_ready_i) state_d = ssym_pkg::CTRL_IDLE;
      default:             state_d = ssym_pkg::CTRL_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ready_o           = (state_q == ssym_pkg::CTRL_IDLE);
    out_load             = (state_q == ssym_pkg::CTRL_DONE) && (!out_valid_q || out_ready_i);

    head_tok             = '0;
    head_tok.active      = in_fire;
    head_tok.mode        = ssym_pkg::mode_e'(mode_i);
    head_tok.scope_ok    = (depth_q != '0);
    head_tok.key         = ID_WIDTH'(id_bits);
    head_tok.top         = LevelW'(depth_q - DepthW'(1));

    wr                   = '0;
    wr.idx               = res_q.free_idx;
    wr.key               = res_q.key;
    wr.level             = res_q.top;

    depth_d              = depth_q;
    status_d             = ssym_pkg::ST_OK;
    hit_top_d            = 1'b0;
    outer_hit_d          = 1'b0;
    outer_level_d        = '0;

    case (res_q.mode)
      ssym_pkg::MODE_PUSH: begin
        if (depth_q == DepthW'(MAX_LEVELS)) begin
          status_d = ssym_pkg::ST_LEVEL_FULL;
        end else begin
          depth_d = depth_q + DepthW'(1);
        end
      end
      ssym_pkg::MODE_INSERT: begin
        if (!res_q.scope_ok) begin
          status_d = ssym_pkg::ST_NO_LEVEL;
        end else begin
          outer_hit_d   = res_q.outer_hit;
          outer_level_d = res_q.outer_level;
          // a duplicate in the top level stores nothing
          if (!res_q.hit_top) begin
            if (!res_q.free_found) begin
              status_d = ssym_pkg::ST_TABLE_FULL;
            end else begin
              wr.en = out_load;
            end
          end
        end
      end
      ssym_pkg::MODE_POP: begin
        if (!res_q.scope_ok) begin
          status_d = ssym_pkg::ST_POP_EMPTY;
        end else begin
          depth_d = depth_q - DepthW'(1);
        end
      end
      ssym_pkg::MODE_FIND: begin
        if (!res_q.scope_ok) begin
          status_d = ssym_pkg::ST_NO_LEVEL;
        end else if (res_q.hit_top) begin
          hit_top_d = 1'b1;
        end else begin
          outer_hit_d   = res_q.outer_hit;
          outer_level_d = res_q.outer_level;
        end
      end
      default: status_d = ssym_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssym_pkg::CTRL_IDLE;
      depth_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        depth_q     <= depth_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (tail_tok.active) begin
      res_q <= tail_tok;
    end
    if (out_load) begin
      status_q      <= status_d;
      hit_top_q     <= hit_top_d;
      outer_hit_q   <= outer_hit_d;
      outer_level_q <= outer_level_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign hit_top_o     = hit_top_q;
  assign outer_hit_o   = outer_hit_q;
  assign outer_level_o = ssym_pkg::OutLvlW'(outer_level_q);
  assign depth_o       = ssym_pkg::DepthW'(depth_q);

  // the token leaves the chain only while the controller waits for it
  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_tok.active |-> (state_q == ssym_pkg::CTRL_SCAN))
    else $error("search token left the chain outside the scan phase");

  a_fire_to_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ssym_pkg::CTRL_SCAN))
    else $error("accepted item did not start a scan");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(MAX_LEVELS))
    else $error("level count beyond the stack size");

  a_write_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr.en |-> (res_q.free_found && !res_q.hit_top && res_q.scope_ok))
    else $error("entry write without a free slot or on a duplicate");

endmodule
